// File: rtl/sbrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrc_pkg
// Shared widths, constants and unit request types for the stereo crusher.
// ----------------------------------------------------------------------------
package sbrc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 32;
    localparam int PHASE_W     = FRAC_BITS + 2;
    localparam int MUL_W       = 34;
    localparam int ACC_W       = 2 * MUL_W;
    localparam int DIV_N_W     = 48;
    localparam int DIV_D_W     = 32;
    localparam int LEN_W       = 6;
    localparam int KNOB_W      = 17;
    localparam int SR_W        = 19;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 19;

    localparam logic [KNOB_W-1:0]    KNOB_ONE  = 17'd65536;
    localparam logic [SR_W-1:0]      BASE_RATE = 19'd44100;
    localparam logic [FRAC_BITS:0]   FX_ONE    = 33'h1_0000_0000;
    localparam logic [PHASE_W-1:0]   PHASE_MAX = 34'h3_FFFF_FFFF;
    localparam logic [FRAC_BITS-1:0] MIN_STEP  = 32'd2147484;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_KNOB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REZ_KNOB    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
        logic [LEN_W-1:0] len;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] n;
        logic [DIV_D_W-1:0] d;
        logic [LEN_W-1:0]   len;
    } t_div_req;

endpackage

// File: rtl/sbrc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrc_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first.
// ----------------------------------------------------------------------------
module sbrc_mul import sbrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_req         i_req,
    output logic [ACC_W-1:0] o_acc,
    output logic             o_done
);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [MUL_W-1:0] r_a, n_a;
    logic [MUL_W-1:0] r_b, n_b;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [MUL_W-1:0] w_addend;
    logic [MUL_W:0]   w_sum;

    always_comb begin
        w_addend = r_b[0] ? r_a : {MUL_W{1'b0}};
        w_sum    = {1'b0, r_acc[ACC_W-1:MUL_W]} + {1'b0, w_addend};
        n_acc    = r_acc;
        n_a      = r_a;
        n_b      = r_b;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_req.start) begin
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_cnt  = i_req.len;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = {w_sum, r_acc[MUL_W-1:1]};
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == LEN_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// File: rtl/sbrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrc_div
// Bit-serial restoring divider, one quotient bit per cycle, msb first.
// ----------------------------------------------------------------------------
module sbrc_div import sbrc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic [DIV_N_W-1:0] o_quot,
    output logic               o_done
);

    logic [DIV_D_W-1:0] r_rem, n_rem;
    logic [DIV_D_W-1:0] r_d, n_d;
    logic [DIV_N_W-1:0] r_n, n_n;
    logic [DIV_N_W-1:0] r_q, n_q;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_ge;

    always_comb begin
        w_trial = {r_rem, r_n[DIV_N_W-1]};
        w_diff  = w_trial - {1'b0, r_d};
        w_ge    = (w_trial >= {1'b0, r_d});
        n_rem   = r_rem;
        n_d     = r_d;
        n_n     = r_n;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_d    = i_req.d;
            n_n    = i_req.n;
            n_q    = '0;
            n_cnt  = i_req.len;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            n_n   = {r_n[DIV_N_W-2:0], 1'b0};
            n_q   = {r_q[DIV_N_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == LEN_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_d   <= n_d;
        r_n   <= n_n;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// File: rtl/stereo_soft_bit_rate_crusher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_soft_bit_rate_crusher
// Stereo sample rate and bit depth crusher with soft re-sampling.
//
// Input stream: one stereo word per item, left in the low half of tdata.
// Output stream: one crushed stereo word per input word, same packing.
// Configuration: plain write port (rate knob, rez knob, host sample rate),
// to be written only while the block is idle; the block does not enforce it.
// One word is worked at a time. All arithmetic runs through one bit-serial
// multiplier and one bit-serial divider, so the time a word takes from
// acceptance to the output register is set by the operand lengths of the
// two serial units; it grows when the phase wraps and grows again when
// depth reduction is active as well.
// The next word is accepted as soon as the current one sits in the output
// register; if the receiver stalls with the register full, the finished
// word waits and no further input is taken until the register drains.
// Reset clears the held, previous and phase state, both smoothed steps and
// the output valid flag, and sets the knobs to full scale and 44100 Hz.
// ----------------------------------------------------------------------------
module stereo_soft_bit_rate_crusher import sbrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [47:0]           i_s_axis_tdata,   // left_sample, right_sample
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [47:0]           o_m_axis_tdata,   // left_out, right_out
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_KA2   = 20'h00002,
        S_KA3   = 20'h00004,
        S_RB2   = 20'h00008,
        S_RB3   = 20'h00010,
        S_TDEP  = 20'h00020,
        S_TAM   = 20'h00040,
        S_TRATE = 20'h00080,
        S_RSM   = 20'h00100,
        S_RSD   = 20'h00200,
        S_DSM   = 20'h00400,
        S_DSD   = 20'h00800,
        S_PHASE = 20'h01000,
        S_RES   = 20'h02000,
        S_SOFT  = 20'h04000,
        S_QCHK  = 20'h08000,
        S_QD    = 20'h10000,
        S_QM    = 20'h20000,
        S_QS    = 20'h40000,
        S_DONE  = 20'h80000
    } t_state;

    localparam logic signed [29:0] SAT_HI = 30'sd8388607;
    localparam logic signed [29:0] SAT_LO = -30'sd8388608;

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [29:0] v);
        logic [SAMPLE_BITS-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;
    logic   r_go, n_go;
    logic   r_ch, n_ch;

    logic [KNOB_W-1:0] r_rate_knob, r_rez_knob;
    logic [SR_W-1:0]   r_sr;

    logic signed [SAMPLE_BITS-1:0] r_in [2], n_in [2];
    logic signed [SAMPLE_BITS-1:0] r_prev [2], n_prev [2];
    logic signed [SAMPLE_BITS-1:0] r_hold [2], n_hold [2];
    logic signed [SAMPLE_BITS-1:0] r_nl [2], n_nl [2];
    logic signed [SAMPLE_BITS-1:0] r_ol [2], n_ol [2];

    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [PHASE_W-1:0]   r_rate_step, n_rate_step;
    logic [PHASE_W-1:0]   r_trate, n_trate;
    logic [FRAC_BITS-1:0] r_depth_step, n_depth_step;
    logic [FRAC_BITS-1:0] r_tdepth, n_tdepth;
    logic [FRAC_BITS:0]   r_ta, n_ta;
    logic [47:0]          r_t, n_t;
    logic [12:0]          r_quot, n_quot;
    logic                 r_out_valid, n_out_valid;
    logic [47:0]          r_out_data, n_out_data;

    t_mul_req           w_mul_req;
    t_div_req           w_div_req;
    logic [ACC_W-1:0]   w_mul_acc;
    logic               w_mul_done;
    logic [DIV_N_W-1:0] w_div_q;
    logic               w_div_done;

    logic                          w_in_acc;
    logic [SR_W-1:0]               w_sr;
    logic [KNOB_W-1:0]             w_ka, w_kb, w_rr;
    logic [FRAC_BITS+1:0]          w_soft_sum;
    logic [FRAC_BITS:0]            w_soft;
    logic signed [SAMPLE_BITS-1:0] w_in_c, w_prev_c, w_hold_c, w_nl_c, w_ol_c;
    logic signed [SAMPLE_BITS:0]   w_res_diff, w_soft_diff;
    logic [SAMPLE_BITS:0]          w_res_mag, w_soft_mag;
    logic [SAMPLE_BITS-1:0]        w_ol_mag;
    logic [33:0]                   w_qn;
    logic [FRAC_BITS:0]            w_one_minus;
    logic [33:0]                   w_ta_sum;
    logic [34:0]                   w_ph_sum, w_ph_sub, w_ph_sel;
    logic [PHASE_W-1:0]            w_ph_new;
    logic                          w_ph_over;
    logic [34:0]                   w_q_sum;
    logic                          w_sign_neg;
    logic [58:0]                   w_rnd_add, w_rsum;
    logic [29:0]                   w_rp_ext;
    logic signed [SAMPLE_BITS-1:0] w_base;
    logic signed [29:0]            w_mix;
    logic [SAMPLE_BITS-1:0]        w_mix_sat;

    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // knob shaping and per-channel operands
    always_comb begin
        w_sr        = (r_sr == '0) ? SR_W'(1) : r_sr;
        w_ka        = (r_rate_knob > KNOB_ONE) ? KNOB_ONE : r_rate_knob;
        w_kb        = (r_rez_knob > KNOB_ONE) ? KNOB_ONE : r_rez_knob;
        w_rr        = KNOB_ONE - w_kb;
        w_soft_sum  = {1'b0, FX_ONE} + {1'b0, r_ta};
        w_soft      = w_soft_sum[FRAC_BITS+1:1];
        w_in_c      = r_in[r_ch];
        w_prev_c    = r_prev[r_ch];
        w_hold_c    = r_hold[r_ch];
        w_nl_c      = r_nl[r_ch];
        w_ol_c      = r_ol[r_ch];
        w_res_diff  = {w_prev_c[SAMPLE_BITS-1], w_prev_c} - {w_in_c[SAMPLE_BITS-1], w_in_c};
        w_soft_diff = {w_nl_c[SAMPLE_BITS-1], w_nl_c} - {w_hold_c[SAMPLE_BITS-1], w_hold_c};
        w_res_mag   = w_res_diff[SAMPLE_BITS] ? (~w_res_diff + 25'd1) : w_res_diff;
        w_soft_mag  = w_soft_diff[SAMPLE_BITS] ? (~w_soft_diff + 25'd1) : w_soft_diff;
        w_ol_mag    = w_ol_c[SAMPLE_BITS-1] ? (~w_ol_c + 24'd1) : w_ol_c;
        w_qn        = {1'b0, w_ol_mag, 9'b0} + {2'b0, r_depth_step} - 34'd1;
        w_one_minus = FX_ONE - {1'b0, r_depth_step};
        w_ta_sum    = w_mul_acc[66:33] + 34'(MIN_STEP);
        w_ph_sum    = {1'b0, r_phase} + {1'b0, r_rate_step};
        w_ph_over   = (w_ph_sum > {2'b0, FX_ONE});
        w_ph_sub    = w_ph_sum - {2'b0, FX_ONE};
        w_ph_sel    = w_ph_over ? w_ph_sub : w_ph_sum;
        w_ph_new    = (w_ph_sel > {1'b0, PHASE_MAX}) ? PHASE_MAX : w_ph_sel[PHASE_W-1:0];
        w_q_sum     = w_mul_acc[55:21] + 35'd256;
    end

    // signed rounding and blend after a product
    always_comb begin
        w_sign_neg = w_ol_c[SAMPLE_BITS-1];
        w_base     = '0;
        if (r_state == S_RES) begin
            w_sign_neg = w_res_diff[SAMPLE_BITS];
            w_base     = w_in_c;
        end else if (r_state == S_SOFT) begin
            w_sign_neg = w_soft_diff[SAMPLE_BITS];
            w_base     = w_hold_c;
        end
        w_rnd_add = (w_sign_neg && (r_state != S_QS)) ? 59'h0_7FFF_FFFF : 59'h0_8000_0000;
        w_rsum    = w_mul_acc[67:9] + w_rnd_add;
        w_rp_ext  = {3'b0, w_rsum[58:32]};
        w_mix     = {{6{w_base[SAMPLE_BITS-1]}}, w_base}
                  + (w_sign_neg ? (~w_rp_ext + 30'd1) : w_rp_ext);
        w_mix_sat = sat_sample(w_mix);
    end

    // serial unit operands
    always_comb begin
        w_mul_req = '0;
        w_div_req = '0;
        unique case (r_state)
            S_KA2: begin
                w_mul_req = '{r_go, MUL_W'(w_ka), MUL_W'(w_ka), LEN_W'(17)};
            end
            S_KA3: begin
                w_mul_req = '{r_go, r_t[MUL_W-1:0], MUL_W'(w_ka), LEN_W'(17)};
            end
            S_RB2: begin
                w_mul_req = '{r_go, MUL_W'(w_rr), MUL_W'(w_rr), LEN_W'(17)};
            end
            S_RB3: begin
                w_mul_req = '{r_go, r_t[MUL_W-1:0], MUL_W'(w_rr), LEN_W'(17)};
            end
            S_TDEP: begin
                w_div_req = '{r_go, {r_t[32:0], 15'b0}, 32'd3, LEN_W'(33)};
            end
            S_TAM: begin
                w_mul_req = '{r_go, MUL_W'(r_ta), MUL_W'(BASE_RATE), LEN_W'(16)};
            end
            S_TRATE: begin
                w_div_req = '{r_go, r_t, DIV_D_W'(w_sr), LEN_W'(48)};
            end
            S_RSM: begin
                w_mul_req = '{r_go, r_rate_step, MUL_W'(999), LEN_W'(10)};
            end
            S_RSD: begin
                w_div_req = '{r_go, r_t, 32'd1000, LEN_W'(48)};
            end
            S_DSM: begin
                w_mul_req = '{r_go, MUL_W'(r_depth_step), MUL_W'(999), LEN_W'(10)};
            end
            S_DSD: begin
                w_div_req = '{r_go, r_t, 32'd1000, LEN_W'(48)};
            end
            S_RES: begin
                w_mul_req = '{r_go, r_phase, MUL_W'(w_res_mag), LEN_W'(25)};
            end
            S_SOFT: begin
                w_mul_req = '{r_go, MUL_W'(w_soft), MUL_W'(w_soft_mag), LEN_W'(25)};
            end
            S_QD: begin
                w_div_req = '{r_go, {w_qn, 14'b0}, r_depth_step, LEN_W'(34)};
            end
            S_QM: begin
                w_mul_req = '{r_go, MUL_W'(r_depth_step), MUL_W'(r_quot), LEN_W'(13)};
            end
            S_QS: begin
                w_mul_req = '{r_go, MUL_W'(w_one_minus), MUL_W'(r_t[24:0]), LEN_W'(25)};
            end
            default: begin
                w_mul_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_go         = 1'b0;
        n_ch         = r_ch;
        n_in         = r_in;
        n_prev       = r_prev;
        n_hold       = r_hold;
        n_nl         = r_nl;
        n_ol         = r_ol;
        n_phase      = r_phase;
        n_rate_step  = r_rate_step;
        n_trate      = r_trate;
        n_depth_step = r_depth_step;
        n_tdepth     = r_tdepth;
        n_ta         = r_ta;
        n_t          = r_t;
        n_quot       = r_quot;
        n_out_valid  = r_out_valid & ~i_m_axis_tready;
        n_out_data   = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_in[0] = i_s_axis_tdata[23:0];
                    n_in[1] = i_s_axis_tdata[47:24];
                    n_state = S_KA2;
                    n_go    = 1'b1;
                end
            end
            S_KA2: begin
                if (w_mul_done) begin
                    n_t     = w_mul_acc[64:17];
                    n_state = S_KA3;
                    n_go    = 1'b1;
                end
            end
            S_KA3: begin
                if (w_mul_done) begin
                    n_ta    = (w_ta_sum > {1'b0, FX_ONE}) ? FX_ONE : w_ta_sum[FRAC_BITS:0];
                    n_state = S_RB2;
                    n_go    = 1'b1;
                end
            end
            S_RB2: begin
                if (w_mul_done) begin
                    n_t     = w_mul_acc[64:17];
                    n_state = S_RB3;
                    n_go    = 1'b1;
                end
            end
            S_RB3: begin
                if (w_mul_done) begin
                    n_t     = 48'(w_mul_acc[66:33]) + 48'd1;
                    n_state = S_TDEP;
                    n_go    = 1'b1;
                end
            end
            S_TDEP: begin
                if (w_div_done) begin
                    n_tdepth = w_div_q[FRAC_BITS-1:0];
                    n_state  = S_TAM;
                    n_go     = 1'b1;
                end
            end
            S_TAM: begin
                if (w_mul_done) begin
                    n_t     = w_mul_acc[65:18] + 48'(w_sr[SR_W-1:1]);
                    n_state = S_TRATE;
                    n_go    = 1'b1;
                end
            end
            S_TRATE: begin
                if (w_div_done) begin
                    n_trate = (w_div_q > 48'(PHASE_MAX)) ? PHASE_MAX : w_div_q[PHASE_W-1:0];
                    n_state = S_RSM;
                    n_go    = 1'b1;
                end
            end
            S_RSM: begin
                if (w_mul_done) begin
                    n_t     = 48'(w_mul_acc[67:24]) + 48'(r_trate) + 48'd500;
                    n_state = S_RSD;
                    n_go    = 1'b1;
                end
            end
            S_RSD: begin
                if (w_div_done) begin
                    n_rate_step = (w_div_q > 48'(PHASE_MAX)) ? PHASE_MAX
                                                             : w_div_q[PHASE_W-1:0];
                    n_state     = S_DSM;
                    n_go        = 1'b1;
                end
            end
            S_DSM: begin
                if (w_mul_done) begin
                    n_t     = 48'(w_mul_acc[67:24]) + 48'(r_tdepth) + 48'd500;
                    n_state = S_DSD;
                    n_go    = 1'b1;
                end
            end
            S_DSD: begin
                if (w_div_done) begin
                    n_depth_step = w_div_q[FRAC_BITS-1:0];
                    n_state      = S_PHASE;
                end
            end
            S_PHASE: begin
                n_phase = w_ph_new;
                if (w_ph_over) begin
                    n_state = S_RES;
                    n_go    = 1'b1;
                end else begin
                    n_ol[0] = r_hold[0];
                    n_ol[1] = r_hold[1];
                    n_state = S_QCHK;
                end
            end
            S_RES: begin
                if (w_mul_done) begin
                    n_nl[r_ch] = w_mix_sat;
                    n_go       = 1'b1;
                    if (!r_ch) begin
                        n_ch = 1'b1;
                    end else begin
                        n_ch    = 1'b0;
                        n_state = S_SOFT;
                    end
                end
            end
            S_SOFT: begin
                if (w_mul_done) begin
                    n_ol[r_ch]   = w_mix_sat;
                    n_hold[r_ch] = r_nl[r_ch];
                    if (!r_ch) begin
                        n_ch = 1'b1;
                        n_go = 1'b1;
                    end else begin
                        n_ch    = 1'b0;
                        n_state = S_QCHK;
                    end
                end
            end
            S_QCHK: begin
                if (r_depth_step > MIN_STEP) begin
                    n_state = S_QD;
                    n_go    = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QD: begin
                if (w_div_done) begin
                    n_quot  = w_div_q[12:0];
                    n_state = S_QM;
                    n_go    = 1'b1;
                end
            end
            S_QM: begin
                if (w_mul_done) begin
                    n_t     = 48'(w_q_sum[34:9]);
                    n_state = S_QS;
                    n_go    = 1'b1;
                end
            end
            S_QS: begin
                if (w_mul_done) begin
                    n_ol[r_ch] = w_mix_sat;
                    if (!r_ch) begin
                        n_ch    = 1'b1;
                        n_state = S_QD;
                        n_go    = 1'b1;
                    end else begin
                        n_ch    = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_ol[1], r_ol[0]};
                    n_prev      = r_in;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_go         <= 1'b0;
            r_ch         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev[0]    <= '0;
            r_prev[1]    <= '0;
            r_hold[0]    <= '0;
            r_hold[1]    <= '0;
            r_phase      <= '0;
            r_rate_step  <= '0;
            r_depth_step <= '0;
        end else begin
            r_state      <= n_state;
            r_go         <= n_go;
            r_ch         <= n_ch;
            r_out_valid  <= n_out_valid;
            r_prev       <= n_prev;
            r_hold       <= n_hold;
            r_phase      <= n_phase;
            r_rate_step  <= n_rate_step;
            r_depth_step <= n_depth_step;
        end
        r_in       <= n_in;
        r_nl       <= n_nl;
        r_ol       <= n_ol;
        r_trate    <= n_trate;
        r_tdepth   <= n_tdepth;
        r_ta       <= n_ta;
        r_t        <= n_t;
        r_quot     <= n_quot;
        r_out_data <= n_out_data;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_knob <= KNOB_ONE;
            r_rez_knob  <= KNOB_ONE;
            r_sr        <= BASE_RATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RATE_KNOB:   r_rate_knob <= i_cfg_data[KNOB_W-1:0];
                REG_REZ_KNOB:    r_rez_knob  <= i_cfg_data[KNOB_W-1:0];
                REG_SAMPLE_RATE: r_sr        <= i_cfg_data[SR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sbrc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_acc   (w_mul_acc),
        .o_done  (w_mul_done)
    );

    sbrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_div_q),
        .o_done  (w_div_done)
    );

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_KA2 && r_go))
        else $error("accepted word did not start the sequence");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_axis_tready)
        |=> (r_state == S_DONE && r_out_valid))
        else $error("finished word overwrote a waiting output");

    a_channel_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QCHK || r_state == S_IDLE || r_state == S_PHASE) |-> !r_ch)
        else $error("channel select not back on left");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo sample rate and bit depth crusher.
//
// Stereo words go in on the slave stream and crushed words come back on the
// master stream. A behavioural model in the bench mirrors the smoothing,
// phase, soft re-sampling and depth rounding. It predicts every word on
// acceptance and checks the results in order. A short table of edge words
// opens the run. Several register settings with random words follow, with
// random gaps on both streams, one long receiver hold-off and one drain
// pause by the sender.
// ----------------------------------------------------------------------------
module tb;
    import sbrc_pkg::*;

    localparam longint unsigned FX       = 64'h1_0000_0000;
    localparam longint unsigned PMAX     = 64'h3_FFFF_FFFF;
    localparam longint unsigned FLOORSTP = 64'd2147484;
    localparam longint signed   SMAX     = 64'sd8388607;
    localparam longint signed   SMIN     = -64'sd8388608;
    localparam int              DRAIN    = 800;
    localparam longint          LIMIT    = 64'd20_000_000;

    typedef struct {
        logic [23:0] l;
        logic [23:0] r;
    } t_pair;

    typedef struct {
        logic        typed;
        logic [23:0] l;
        logic [23:0] r;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [47:0]           i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [47:0]           o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_RATE_KNOB;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // model state
    longint unsigned rate_knob_m, rez_knob_m, sr_hz_m;
    longint signed   prev_l, prev_r, held_l, held_r;
    longint unsigned phase_m, rstep_m, dstep_m;

    t_pair  crushed_q[$];
    t_row   typed_q[$];
    int     errors = 0;
    longint cycles = 0;
    bit     long_hold = 1'b0;

    stereo_soft_bit_rate_crusher dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch %s at %0t", msg, $realtime);
        errors++;
    endtask

    function automatic longint signed sat24(input longint signed v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint signed rnd32(input longint signed v);
        return (v + 64'sd2147483648) >>> 32;
    endfunction

    function automatic longint signed resample(input longint signed p, input longint signed x,
                                               input longint unsigned ph);
        return sat24(x + rnd32((p - x) * longint'(ph)));
    endfunction

    function automatic longint signed round_to_step(input longint signed x,
                                                    input longint unsigned st);
        longint unsigned m, q, q23, rr;
        m   = longint'(x < 0 ? -x : x) << 9;
        q   = ((m + st - 1) / st) * st;
        q23 = (q + 256) >> 9;
        rr  = (q23 * (FX - st) + (FX >> 1)) >> 32;
        return x < 0 ? -longint'(rr) : longint'(rr);
    endfunction

    function automatic t_pair crush_pair(input logic [47:0] w);
        longint signed   inl, inr, ol, orr, nl, nr;
        longint unsigned sr, ka, kb, r, ta, blend, trate, tdepth, ph;
        t_pair           res;
        inl = longint'($signed(w[23:0]));
        inr = longint'($signed(w[47:24]));
        sr  = sr_hz_m == 0 ? 1 : sr_hz_m;
        ka  = rate_knob_m > 65536 ? 65536 : rate_knob_m;
        kb  = rez_knob_m > 65536 ? 65536 : rez_knob_m;
        r   = 65536 - kb;
        ta  = ((ka * ka * ka) >> 16) + FLOORSTP;
        if (ta > FX) ta = FX;
        blend = (FX + ta) >> 1;
        trate = (ta * 44100 + sr / 2) / sr;
        if (trate > PMAX) trate = PMAX;
        tdepth = (((r * r * r) >> 16) + 1) / 3;
        rstep_m = (rstep_m * 999 + trate + 500) / 1000;
        if (rstep_m > PMAX) rstep_m = PMAX;
        dstep_m = (dstep_m * 999 + tdepth + 500) / 1000;
        ol  = held_l;
        orr = held_r;
        ph  = phase_m + rstep_m;
        if (ph > FX) begin
            ph = ph - FX;
            if (ph > PMAX) ph = PMAX;
            nl  = resample(prev_l, inl, ph);
            nr  = resample(prev_r, inr, ph);
            ol  = held_l + rnd32((nl - held_l) * longint'(blend));
            orr = held_r + rnd32((nr - held_r) * longint'(blend));
            held_l = nl;
            held_r = nr;
        end
        if (ph > PMAX) ph = PMAX;
        phase_m = ph;
        if (dstep_m > FLOORSTP) begin
            ol  = round_to_step(ol, dstep_m);
            orr = round_to_step(orr, dstep_m);
        end
        prev_l = inl;
        prev_r = inr;
        res.l = 24'(sat24(ol));
        res.r = 24'(sat24(orr));
        return res;
    endfunction

    // prediction on acceptance
    always @(posedge i_clk) begin
        t_pair p;
        t_row  t;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            p = crush_pair(i_s_axis_tdata);
            t = typed_q.pop_front();
            if (t.typed) begin
                p.l = t.l;
                p.r = t.r;
            end
            crushed_q.push_back(p);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_pair p;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (crushed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %012h", o_m_axis_tdata));
            end else begin
                p = crushed_q.pop_front();
                if (o_m_axis_tdata[23:0] !== p.l)
                    report_mismatch($sformatf("left_out: got %06h want %06h",
                                              o_m_axis_tdata[23:0], p.l));
                if (o_m_axis_tdata[47:24] !== p.r)
                    report_mismatch($sformatf("right_out: got %06h want %06h",
                                              o_m_axis_tdata[47:24], p.r));
            end
        end
    end

    // receiver
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                k = $urandom_range(0, 19);
                if (k < 12) begin
                    i_m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 60)) @(posedge i_clk);
                end else begin
                    i_m_axis_tready <= 1'b0;
                    repeat (k == 19 ? $urandom_range(50, 400) : $urandom_range(1, 4))
                        @(posedge i_clk);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_RATE_KNOB:   rate_knob_m = v & 19'h1FFFF;
            REG_REZ_KNOB:    rez_knob_m  = v & 19'h1FFFF;
            REG_SAMPLE_RATE: sr_hz_m     = v;
            default: ;
        endcase
    endtask

    task automatic settle();
        wait (crushed_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic setup(input logic [18:0] rk, input logic [18:0] zk, input logic [18:0] sr);
        settle();
        write_reg(REG_RATE_KNOB, rk);
        write_reg(REG_REZ_KNOB, zk);
        write_reg(REG_SAMPLE_RATE, sr);
    endtask

    // one word; leaves tvalid high when no gap follows
    task automatic send_word(input logic [47:0] w, input t_row t);
        int g;
        typed_q.push_back(t);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        do @(posedge i_clk); while (!o_s_axis_tready);
        g = $urandom_range(0, 9);
        if (g >= 5) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g == 9 ? $urandom_range(100, 900) : $urandom_range(1, 6))
                @(posedge i_clk);
        end
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_words(input int n);
        t_row none;
        none.typed = 1'b0;
        none.l = '0;
        none.r = '0;
        repeat (n) send_word({rand_sample(), rand_sample()}, none);
        i_s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        t_row        t;
        logic [47:0] edge_rows[25];
        rate_knob_m = 65536;
        rez_knob_m  = 65536;
        sr_hz_m     = 44100;
        prev_l = 0; prev_r = 0; held_l = 0; held_r = 0;
        phase_m = 0; rstep_m = 0; dstep_m = 0;
        edge_rows = '{
            {24'h000000, 24'h000000}, {24'h7FFFFF, 24'h7FFFFF}, {24'h800000, 24'h800000},
            {24'h7FFFFF, 24'h800000}, {24'h800000, 24'h7FFFFF}, {24'hFFFFFF, 24'h000001},
            {24'h000001, 24'hFFFFFF}, {24'h555555, 24'hAAAAAA}, {24'hAAAAAA, 24'h555555},
            {24'h400000, 24'hC00000}, {24'hC00000, 24'h400000}, {24'h000000, 24'h7FFFFF},
            {24'h800000, 24'h000000}, {24'h7FFFFE, 24'h800001}, {24'h123456, 24'hEDCBA9},
            {24'hFFFFFF, 24'hFFFFFF}, {24'h000001, 24'h000001}, {24'h7FFFFF, 24'h7FFFFF},
            {24'h800000, 24'h800000}, {24'h0F0F0F, 24'hF0F0F0}, {24'hF0F0F0, 24'h0F0F0F},
            {24'h000000, 24'h000000}, {24'h7FFFFF, 24'h800000}, {24'h3FFFFF, 24'hBFFFFF},
            {24'h000000, 24'h000000}};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase stays below one for the first words, so the held zero comes out
        t.typed = 1'b1;
        t.l = '0;
        t.r = '0;
        foreach (edge_rows[i]) send_word(edge_rows[i], t);
        i_s_axis_tvalid <= 1'b0;
        random_words(250);

        setup(19'd0, 19'd0, 19'd8000);
        long_hold = 1'b1;
        random_words(300);

        // knobs above range, zero host rate: extrapolating re-sample
        setup(19'h7FFFF, 19'h7FFFF, 19'd0);
        random_words(150);
        wait (crushed_q.size() == 0);
        random_words(150);

        setup(19'd65536, 19'd0, 19'h7FFFF);
        random_words(250);

        setup(19'd0, 19'd65536, 19'd384000);
        random_words(200);

        setup(19'($urandom_range(0, 65536)), 19'($urandom_range(0, 65536)),
              19'($urandom_range(8000, 384000)));
        random_words(250);

        setup(19'($urandom_range(0, 131071)), 19'($urandom_range(0, 40000)),
              19'($urandom_range(8000, 96000)));
        random_words(250);

        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sbrc_pkg.sv
rtl/sbrc_mul.sv
rtl/sbrc_div.sv
rtl/stereo_soft_bit_rate_crusher.sv
tb/tb.sv
